// File: hw/rtl/btpc_pkg.sv
`timescale 1ns / 1ps
package btpc_pkg;
    localparam int RawW   = 20;
    localparam int TempW  = 16;
    localparam int PresW  = 32;
    localparam int CalW   = 48;
    localparam int DivW   = 64;

    localparam logic [1:0] RegCalT  = 2'd0;
    localparam logic [1:0] RegCalPa = 2'd1;
    localparam logic [1:0] RegCalPb = 2'd2;
    localparam logic [1:0] RegCalPc = 2'd3;

    typedef struct packed {
        logic [RawW-1:0] raw_temperature;
        logic [RawW-1:0] adc_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [TempW-1:0] temperature_centi;
        logic [PresW-1:0]        pressure_q24_8;
        logic                    divide_fault;
    } t_out_item;

    typedef struct packed {
        logic [CalW-1:0] cal_t;
        logic [CalW-1:0] cal_pa;
        logic [CalW-1:0] cal_pb;
        logic [CalW-1:0] cal_pc;
    } t_cal;

    function automatic logic [63:0] sx16(input logic [15:0] w);
        sx16 = {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        asr64 = 64'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        asr32 = 32'($signed(x) >>> n);
    endfunction
endpackage

// File: hw/rtl/btpc_stream_if.sv
`timescale 1ns / 1ps
interface btpc_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/btpc_cfg_regs.sv
`timescale 1ns / 1ps
module btpc_cfg_regs
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cal        o_cal
);
    logic [CalW-1:0] r_t, r_pa, r_pb, r_pc;
    logic [1:0] w_idx;
    assign w_idx  = paddr[4:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= '0; r_pa <= '0; r_pb <= '0; r_pc <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                RegCalT:  r_t  <= pwdata[CalW-1:0];
                RegCalPa: r_pa <= pwdata[CalW-1:0];
                RegCalPb: r_pb <= pwdata[CalW-1:0];
                RegCalPc: r_pc <= pwdata[CalW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            RegCalT:  prdata = {16'd0, r_t};
            RegCalPa: prdata = {16'd0, r_pa};
            RegCalPb: prdata = {16'd0, r_pb};
            RegCalPc: prdata = {16'd0, r_pc};
            default:  prdata = '0;
        endcase
    end

    assign o_cal = '{cal_t: r_t, cal_pa: r_pa, cal_pb: r_pb, cal_pc: r_pc};
endmodule

// File: hw/rtl/btpc_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Carries a sideband word alongside each item.
module btpc_divider
    import btpc_pkg::*;
#(
    parameter int SideW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DivW-1:0]  i_num,
    input  logic [DivW-1:0]  i_den,
    input  logic             i_neg,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [DivW-1:0]  o_quot,
    output logic [SideW-1:0] o_side
);
    logic [DivW-1:0]  r_rem  [DivW+1];
    logic [DivW-1:0]  r_num  [DivW+1];
    logic [DivW-1:0]  r_den  [DivW+1];
    logic             r_neg  [DivW+1];
    logic             r_vld  [DivW+1];
    logic [SideW-1:0] r_side [DivW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DivW; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < DivW; s++) r_vld[s+1] <= r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int s = 0; s < DivW; s++) begin
                logic [DivW:0] n_trial;
                n_trial = {r_rem[s], r_num[s][DivW-1]} - {1'b0, r_den[s]};
                if (!n_trial[DivW]) begin
                    r_rem[s+1] <= n_trial[DivW-1:0];
                    r_num[s+1] <= {r_num[s][DivW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= {r_rem[s][DivW-2:0], r_num[s][DivW-1]};
                    r_num[s+1] <= {r_num[s][DivW-2:0], 1'b0};
                end
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[DivW];
    assign o_quot  = r_neg[DivW] ? 64'(0 - r_num[DivW]) : r_num[DivW];
    assign o_side  = r_side[DivW];
endmodule

// File: hw/rtl/btpc_datapath.sv
`timescale 1ns / 1ps
// Stage chain: temperature, pressure prep, divider, pressure finish.
// Whole chain advances on i_en; valid bits travel with the data.
// 64x64 products are built from 32-bit partials; one multiply level per stage.
module btpc_datapath
    import btpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  t_cal      i_cal,
    output logic      o_valid,
    output t_out_item o_item
);
    localparam int Pre = 8;
    localparam int Post = 5;

    // 64-bit wrapping product, split into 32x32 partials
    function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] lo, m1, m2;
        lo = 64'(a[31:0]) * 64'(b[31:0]);
        m1 = 64'(a[63:32]) * 64'(b[31:0]);
        m2 = 64'(a[31:0]) * 64'(b[63:32]);
        mul64 = lo + {m1[31:0], 32'd0} + {m2[31:0], 32'd0};
    endfunction

    // front stages
    logic            r_v  [Pre];
    logic [RawW-1:0] r_rp [Pre];
    logic [31:0] r_a, r_b, r_at2, r_bb, r_v1t, r_v2tm, r_tf;
    logic [15:0] r_tc [4:Pre-1];
    logic [63:0] r_v1, r_v1sq, r_v1p5, r_v1p2, r_v2a, r_v1sqp3;
    logic [63:0] r_v2, r_v1b;

    logic [15:0] t1;
    assign t1 = i_cal.cal_t[15:0];

    function automatic logic [15:0] sat16(input logic [31:0] x);
        if ($signed(x) > 32767) sat16 = 16'h7fff;
        else if ($signed(x) < -32768) sat16 = 16'h8000;
        else sat16 = x[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Pre; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < Pre; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[0] <= i_item.adc_pressure;
            for (int s = 1; s < Pre; s++) r_rp[s] <= r_rp[s-1];
            for (int s = 5; s < Pre; s++) r_tc[s] <= r_tc[s-1];
            // s0
            r_a <= 32'(i_item.raw_temperature >> 3) - {15'd0, t1, 1'b0};
            r_b <= 32'(i_item.raw_temperature >> 4) - {16'd0, t1};
            // s1
            r_at2 <= r_a * 32'(sx16(i_cal.cal_t[31:16]));
            r_bb  <= r_b * r_b;
            // s2
            r_v1t  <= asr32(r_at2, 11);
            r_v2tm <= asr32(r_bb, 12) * 32'(sx16(i_cal.cal_t[47:32]));
            // s3
            r_tf   <= asr32(r_v1t, 0) + asr32(r_v2tm, 14);
            // s4: temperature out, v1
            r_tc[4] <= sat16(asr32(r_tf * 32'd5 + 32'd128, 8));
            r_v1   <= {{32{r_tf[31]}}, r_tf} - 64'd128000;
            // s5
            r_v1sq <= mul64(r_v1, r_v1);
            r_v1p5 <= mul64(r_v1, sx16(i_cal.cal_pb[31:16]));
            r_v1p2 <= mul64(r_v1, sx16(i_cal.cal_pa[31:16]));
            // s6
            r_v2a    <= mul64(r_v1sq, sx16(i_cal.cal_pb[47:32]))
                        + {r_v1p5[46:0], 17'd0} + (sx16(i_cal.cal_pb[15:0]) << 35);
            r_v1sqp3 <= asr64(mul64(r_v1sq, sx16(i_cal.cal_pa[47:32])), 8)
                        + {r_v1p2[51:0], 12'd0};
            // s7
            r_v2  <= r_v2a;
            r_v1b <= asr64(mul64(64'h0000_8000_0000_0000 + r_v1sqp3,
                                 {48'd0, i_cal.cal_pa[15:0]}), 33);
        end
    end

    // divider front: numerator and magnitudes
    logic [63:0] w_pn, w_num;
    assign w_pn  = 64'd1048576 - {44'd0, r_rp[Pre-1]};
    assign w_num = mul64({w_pn[32:0], 31'd0} - r_v2, 64'd3125);

    logic [63:0] w_an, w_ad;
    assign w_an = w_num[63] ? 64'(0 - w_num) : w_num;
    assign w_ad = r_v1b[63] ? 64'(0 - r_v1b) : r_v1b;

    localparam int SideW = 17;
    logic [SideW-1:0] w_side_in, w_side_out;
    logic             w_dv;
    logic [63:0]      w_q;
    assign w_side_in = {r_v1b == 64'd0, r_tc[Pre-1]};

    btpc_divider #(.SideW(SideW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
        .i_valid(r_v[Pre-1]), .i_num(w_an), .i_den(w_ad),
        .i_neg(w_num[63] ^ r_v1b[63]), .i_side(w_side_in),
        .o_valid(w_dv), .o_quot(w_q), .o_side(w_side_out)
    );

    // back stages
    logic             r_bv [Post];
    logic [SideW-1:0] r_bs [Post];
    logic [63:0] r_p0, r_p1, r_p2, r_ps, r_ps1, r_w2, r_w2b, r_w2c;
    logic [63:0] r_pps, r_pss, r_sum, r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Post; s++) r_bv[s] <= 1'b0;
        end else if (i_en) begin
            r_bv[0] <= w_dv;
            for (int s = 1; s < Post; s++) r_bv[s] <= r_bv[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bs[0] <= w_side_out;
            for (int s = 1; s < Post; s++) r_bs[s] <= r_bs[s-1];
            // b0
            r_p0  <= w_q;
            r_ps  <= asr64(w_q, 13);
            r_w2  <= asr64(mul64(sx16(i_cal.cal_pc[31:16]), w_q), 19);
            // b1
            r_p1  <= r_p0;
            r_ps1 <= r_ps;
            r_w2b <= r_w2;
            r_pps <= mul64(sx16(i_cal.cal_pc[47:32]), r_ps);
            // b2
            r_p2  <= r_p1;
            r_w2c <= r_w2b;
            r_pss <= mul64(r_pps, r_ps1);
            // b3
            r_sum <= r_p2 + asr64(r_pss, 25) + r_w2c;
            // b4
            r_fin <= asr64(r_sum, 8) + (sx16(i_cal.cal_pc[15:0]) << 4);
        end
    end

    logic [31:0] w_pq;
    always_comb begin
        if (r_bs[Post-1][16] || r_fin[63]) w_pq = '0;
        else if (r_fin[63:32] != 32'd0) w_pq = '1;
        else w_pq = r_fin[31:0];
    end

    assign o_valid = r_bv[Post-1];
    assign o_item  = '{temperature_centi: r_bs[Post-1][15:0],
                       pressure_q24_8: w_pq, divide_fault: r_bs[Post-1][16]};
endmodule

// File: hw/rtl/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
// Depth: 78 register stages, most of them in the 65-stage divider.
// Throughput: one item per cycle while no untaken result stalls the pipe.
// The whole pipe halts while its last result is not taken (skid-free hold).
// Reset (synchronous, active low) clears all valid bits and calibration.
module baro_temp_pressure_compensation_top
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    btpc_stream_if.sink   s_in,
    btpc_stream_if.source m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    t_cal      w_cal;
    t_out_item w_out;
    logic      w_ov, w_en;

    btpc_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cal(w_cal)
    );

    assign w_en = !w_ov || m_out.ready;
    assign s_in.ready = w_en;

    btpc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(s_in.valid), .i_item(t_in_item'(s_in.data)),
        .i_cal(w_cal), .o_valid(w_ov), .o_item(w_out)
    );

    assign m_out.valid = w_ov;
    assign m_out.data  = w_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ov && !m_out.ready |=> w_ov && $stable(w_out)) else $error("result lost");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ov |-> s_in.ready) else $error("stall without result");
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ov && w_out.divide_fault |-> w_out.pressure_q24_8 == 32'd0)
        else $error("fault with pressure");
endmodule
